// File: design/cgm_pkg.sv
// cgm_pkg: shared types and constants for the cosine gallery matcher.
// No dependencies; imported by every cgm module.
`timescale 1ns / 1ps

package cgm_pkg;

   // Widths of the stream fields
   localparam int SLOT_FW  = 6;
   localparam int INDEX_FW = 9;
   localparam int VALUE_FW = 16;
   localparam int SCORE_FW = 16;
   localparam int THR_FW   = 15;

   // Q1.15 score limits
   localparam logic signed [SCORE_FW-1:0] SCORE_MIN = 16'sh8000;
   localparam logic signed [SCORE_FW-1:0] SCORE_MAX = 16'sh7FFF;
   localparam logic [THR_FW-1:0] THR_RESET = 15'd16384;

   // Extra fraction bits applied to dot^2 (2 * 15)
   localparam int FRAC2 = 30;

   localparam logic ACTION_GALLERY = 1'b0;
   localparam logic ACTION_QUERY   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LEN,
      ST_MAC,
      ST_NORM,
      ST_WAIT,
      ST_CMP,
      ST_OUT
   } cgm_state_type;

   typedef enum logic [2:0] {
      SC_IDLE,
      SC_MUL,
      SC_PREP,
      SC_CAND,
      SC_TEST
   } sc_state_type;

endpackage

// File: design/cgm_gallery.sv
// cgm_gallery: gallery element memory and per-slot length memory.
// Both are single-write, single-read synchronous RAMs; uses cgm_pkg.
`timescale 1ns / 1ps

module cgm_gallery
   import cgm_pkg::*;
#(
   parameter int SLOTS = 64,
   parameter int DIM   = 512,
   parameter int GA_W  = 15,
   parameter int SW    = 6,
   parameter int LW    = 10
) (
   input  logic                       clock,
   input  logic                       el_we,
   input  logic [GA_W-1:0]            el_waddr,
   input  logic signed [VALUE_FW-1:0] el_wdata,
   input  logic [GA_W-1:0]            el_raddr,
   output logic signed [VALUE_FW-1:0] el_rdata,
   input  logic                       len_we,
   input  logic [SW-1:0]              len_waddr,
   input  logic [LW-1:0]              len_wdata,
   input  logic [SW-1:0]              len_raddr,
   output logic [LW-1:0]              len_rdata
);

   logic signed [VALUE_FW-1:0] el_mem [SLOTS*DIM];
   logic [LW-1:0]              len_mem [SLOTS];

   always_ff @(posedge clock) begin
      if (el_we) begin
         el_mem[el_waddr] <= el_wdata;
      end
      el_rdata <= el_mem[el_raddr];
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      len_rdata <= len_mem[len_raddr];
   end

endmodule

// File: design/cgm_score.sv
// cgm_score: sequential cosine score unit. Forms na*nb and dot^2 by shift-add,
// then finds floor(32768*|dot|/sqrt(na*nb)) one bit at a time. Uses cgm_pkg.
`timescale 1ns / 1ps

module cgm_score
   import cgm_pkg::*;
#(
   parameter int NW = 40
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [NW:0]         dot,
   input  logic [NW-1:0]              na,
   input  logic [NW-1:0]              nb,
   output logic                       done,
   output logic signed [SCORE_FW-1:0] score
);

   localparam int PW = 2 * NW;
   localparam int W  = PW + FRAC2 + 3;
   localparam int KW = $clog2(NW + 1);

   sc_state_type state_ff, state_in;

   logic [KW-1:0]         k_ff, k_in;
   logic [3:0]            b_ff, b_in;
   logic [PW-1:0]         na_sh_ff, na_sh_in, ad_sh_ff, ad_sh_in;
   logic [NW-1:0]         nb_sh_ff, nb_sh_in, ad_m_ff, ad_m_in;
   logic [PW-1:0]         p_acc_ff, p_acc_in, r_acc_ff, r_acc_in;
   logic [W-1:0]          p2_ff, p2_in, r_ff, r_in, t_ff, t_in, u_ff, u_in;
   logic [W-1:0]          cand_ff, cand_in;
   logic [SCORE_FW-1:0]   m_ff, m_in;
   logic                  neg_ff, neg_in;
   logic                  done_ff, done_in;
   logic signed [SCORE_FW-1:0] score_ff, score_in;
   logic [NW:0]           ad_full;
   logic [W-1:0]          u_upd;

   assign ad_full = dot[NW] ? (NW+1)'(-dot) : (NW+1)'(dot);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SC_IDLE: if (start) state_in = SC_MUL;
         SC_MUL:  if (k_ff == KW'(NW - 1)) state_in = SC_PREP;
         SC_PREP: state_in = SC_CAND;
         SC_CAND: state_in = SC_TEST;
         SC_TEST: state_in = (b_ff == 4'd0) ? SC_IDLE : SC_CAND;
         default: state_in = SC_IDLE;
      endcase
   end

   always_comb begin
      k_in     = k_ff;
      b_in     = b_ff;
      na_sh_in = na_sh_ff;
      ad_sh_in = ad_sh_ff;
      nb_sh_in = nb_sh_ff;
      ad_m_in  = ad_m_ff;
      p_acc_in = p_acc_ff;
      r_acc_in = r_acc_ff;
      p2_in    = p2_ff;
      r_in     = r_ff;
      t_in     = t_ff;
      u_in     = u_ff;
      cand_in  = cand_ff;
      m_in     = m_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      score_in = score_ff;
      u_upd    = u_ff;
      unique case (state_ff)
         SC_IDLE: begin
            if (start) begin
               k_in     = '0;
               na_sh_in = PW'(na);
               nb_sh_in = nb;
               // |dot| never exceeds 2^(NW-1), so NW bits hold it
               ad_m_in  = ad_full[NW-1:0];
               ad_sh_in = PW'(ad_full[NW-1:0]);
               p_acc_in = '0;
               r_acc_in = '0;
               neg_in   = dot[NW];
            end
         end
         SC_MUL: begin
            if (nb_sh_ff[0]) p_acc_in = p_acc_ff + na_sh_ff;
            if (ad_m_ff[0])  r_acc_in = r_acc_ff + ad_sh_ff;
            na_sh_in = na_sh_ff << 1;
            ad_sh_in = ad_sh_ff << 1;
            nb_sh_in = nb_sh_ff >> 1;
            ad_m_in  = ad_m_ff >> 1;
            k_in     = k_ff + KW'(1);
         end
         SC_PREP: begin
            p2_in = W'(p_acc_ff) << FRAC2;
            r_in  = W'(r_acc_ff) << FRAC2;
            t_in  = '0;
            u_in  = '0;
            m_in  = '0;
            b_in  = 4'd15;
         end
         SC_CAND: begin
            // (m + 2^b)^2 * P = T + U + P*4^b
            cand_in = t_ff + u_ff + p2_ff;
         end
         SC_TEST: begin
            if (cand_ff <= r_ff) begin
               t_in       = cand_ff;
               u_upd      = u_ff + (p2_ff << 1);
               m_in[b_ff] = 1'b1;
            end
            u_in  = u_upd >> 1;
            p2_in = p2_ff >> 2;
            b_in  = b_ff - 4'd1;
            if (b_ff == 4'd0) begin
               done_in = 1'b1;
               if (neg_ff) begin
                  score_in = $signed(-m_in);
               end else if (m_in[SCORE_FW-1]) begin
                  score_in = SCORE_MAX;
               end else begin
                  score_in = $signed(m_in);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      b_ff     <= b_in;
      na_sh_ff <= na_sh_in;
      ad_sh_ff <= ad_sh_in;
      nb_sh_ff <= nb_sh_in;
      ad_m_ff  <= ad_m_in;
      p_acc_ff <= p_acc_in;
      r_acc_ff <= r_acc_in;
      p2_ff    <= p2_in;
      r_ff     <= r_in;
      t_ff     <= t_in;
      u_ff     <= u_in;
      cand_ff  <= cand_in;
      m_ff     <= m_in;
      neg_ff   <= neg_in;
      score_ff <= score_in;
   end

   assign done  = done_ff;
   assign score = score_ff;

endmodule

// File: design/cosine_gallery_matcher.sv
// cosine_gallery_matcher: top level with item intake, slot scan sequencer,
// query memory and MAC pipeline. Uses cgm_pkg, cgm_gallery and cgm_score.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tdata, tuser=action, tlast=last
//  rsp     | out | rsp_tvalid/rsp_tready | tdata {accepted,score,best_slot,found}
//  csr     | in  | csr_valid/csr_ready   | csr_data = match_threshold
//
// Gallery writes and non-last query beats only write memory. A last query beat
// scans all SLOTS: an invalid slot is skipped, a slot of other length is compared
// with a score of zero, and a slot of matching length runs the MAC and then the
// score unit (score zero if a norm is zero); then the result is loaded.
// Intake stalls during the scan and while a finished result waits for rsp.
// Reset is synchronous; it clears slot valid bits and sets the threshold.
`timescale 1ns / 1ps

module cosine_gallery_matcher
   import cgm_pkg::*;
#(
   parameter int SLOTS = 64,
   parameter int DIM   = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // slot[5:0], element_index[14:6], value[30:15], pad
   input  logic        req_tuser,  // action
   input  logic        req_tlast,  // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // found[0], best_slot[6:1], score[22:7], accepted[23]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [14:0] csr_data
);

   localparam int SW   = $clog2(SLOTS);
   localparam int IW   = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int LW   = $clog2(DIM + 1);
   localparam int GA_W = $clog2(SLOTS * DIM);
   localparam int NW   = 31 + IW;

   cgm_state_type state_ff, state_in;

   logic [SLOT_FW-1:0]         f_slot;
   logic [INDEX_FW-1:0]        f_idx;
   logic signed [VALUE_FW-1:0] f_value;
   logic                       take, idx_ok, slot_ok;

   logic [SW-1:0]  s_ff, s_in;
   logic [LW-1:0]  qlen_ff, qlen_in, i_ff, i_in;
   logic           rd_v_ff, mul_v_ff, iss;
   logic [SLOTS-1:0] valid_ff;

   logic signed [VALUE_FW-1:0] q_mem [DIM];
   logic signed [VALUE_FW-1:0] q_rdata, g_rdata;
   logic [LW-1:0]              len_rdata;

   logic signed [2*VALUE_FW-1:0] p_ab_ff, p_aa_ff, p_bb_ff;
   logic signed [NW:0]           dot_ff, dot_in;
   logic [NW-1:0]                na_ff, na_in, nb_ff, nb_in;

   logic signed [SCORE_FW-1:0] sc_ff, sc_in, best_ff, best_in, unit_score;
   logic [SW-1:0]              best_slot_ff, best_slot_in;
   logic                       found_ff, found_in, unit_done, unit_start;
   logic [THR_FW-1:0]          thr_ff;
   logic                       rsp_v_ff;
   logic [23:0]                rsp_d_ff;
   logic                       last_slot, out_load;

   logic [GA_W-1:0] g_waddr, g_raddr;

   assign f_slot  = req_tdata[5:0];
   assign f_idx   = req_tdata[14:6];
   assign f_value = $signed(req_tdata[30:15]);

   assign take    = req_tvalid && req_tready;
   assign idx_ok  = 32'(f_idx) < DIM;
   assign slot_ok = 32'(f_slot) < SLOTS;
   assign last_slot = (s_ff == SW'(SLOTS - 1));
   assign iss     = (state_ff == ST_MAC) && (i_ff < qlen_ff);

   assign g_waddr = GA_W'(SW'(f_slot)) * GA_W'(DIM) + GA_W'(IW'(f_idx));
   assign g_raddr = GA_W'(s_ff) * GA_W'(DIM) + GA_W'(i_ff);

   cgm_gallery #(
      .SLOTS (SLOTS),
      .DIM   (DIM),
      .GA_W  (GA_W),
      .SW    (SW),
      .LW    (LW)
   ) u_gallery (
      .clock     (clock),
      .el_we     (take && req_tuser == ACTION_GALLERY && idx_ok && slot_ok),
      .el_waddr  (g_waddr),
      .el_wdata  (f_value),
      .el_raddr  (g_raddr),
      .el_rdata  (g_rdata),
      .len_we    (take && req_tuser == ACTION_GALLERY && idx_ok && slot_ok && req_tlast),
      .len_waddr (SW'(f_slot)),
      .len_wdata (LW'(f_idx) + LW'(1)),
      .len_raddr (s_ff),
      .len_rdata (len_rdata)
   );

   cgm_score #(
      .NW (NW)
   ) u_score (
      .clock (clock),
      .reset (reset),
      .start (unit_start),
      .dot   (dot_ff),
      .na    (na_ff),
      .nb    (nb_ff),
      .done  (unit_done),
      .score (unit_score)
   );

   // query memory
   always_ff @(posedge clock) begin
      if (take && req_tuser == ACTION_QUERY && idx_ok) begin
         q_mem[IW'(f_idx)] <= f_value;
      end
      q_rdata <= q_mem[IW'(i_ff)];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && req_tuser == ACTION_QUERY && idx_ok && req_tlast) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (valid_ff[s_ff]) state_in = ST_LEN;
            else if (last_slot) state_in = ST_OUT;
         end
         ST_LEN:  state_in = (len_rdata == qlen_ff) ? ST_MAC : ST_CMP;
         ST_MAC:  if (!iss && !rd_v_ff && !mul_v_ff) state_in = ST_NORM;
         ST_NORM: state_in = (na_ff == '0 || nb_ff == '0) ? ST_CMP : ST_WAIT;
         ST_WAIT: if (unit_done) state_in = ST_CMP;
         ST_CMP:  state_in = last_slot ? ST_OUT : ST_SCAN;
         ST_OUT:  if (!rsp_v_ff) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      unit_start = (state_ff == ST_NORM) && na_ff != '0 && nb_ff != '0;
      out_load   = (state_ff == ST_OUT) && !rsp_v_ff;
   end

   // datapath next values
   always_comb begin
      s_in         = s_ff;
      qlen_in      = qlen_ff;
      i_in         = i_ff;
      dot_in       = dot_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      sc_in        = sc_ff;
      best_in      = best_ff;
      best_slot_in = best_slot_ff;
      found_in     = found_ff;
      case (state_ff)
         ST_IDLE: begin
            qlen_in      = LW'(f_idx) + LW'(1);
            s_in         = '0;
            best_in      = SCORE_MIN;
            best_slot_in = '0;
            found_in     = 1'b0;
         end
         ST_SCAN: begin
            if (!valid_ff[s_ff] && !last_slot) s_in = s_ff + SW'(1);
         end
         ST_LEN: begin
            i_in   = '0;
            dot_in = '0;
            na_in  = '0;
            nb_in  = '0;
            sc_in  = '0;
         end
         ST_MAC: begin
            if (iss) i_in = i_ff + LW'(1);
            if (mul_v_ff) begin
               dot_in = dot_ff + (NW+1)'(p_ab_ff);
               na_in  = na_ff + NW'($unsigned(p_aa_ff));
               nb_in  = nb_ff + NW'($unsigned(p_bb_ff));
            end
         end
         ST_WAIT: if (unit_done) sc_in = unit_score;
         ST_CMP: begin
            if (sc_ff > best_ff) begin
               best_in      = sc_ff;
               best_slot_in = s_ff;
               found_in     = 1'b1;
            end
            if (!last_slot) s_in = s_ff + SW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         thr_ff   <= THR_RESET;
         rsp_v_ff <= 1'b0;
         rd_v_ff  <= 1'b0;
         mul_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_v_ff  <= iss;
         mul_v_ff <= rd_v_ff;
         if (take && req_tuser == ACTION_GALLERY && idx_ok && slot_ok && req_tlast) begin
            valid_ff[SW'(f_slot)] <= 1'b1;
         end
         if (csr_valid && csr_ready) thr_ff <= csr_data;
         if (out_load) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      s_ff         <= s_in;
      qlen_ff      <= qlen_in;
      i_ff         <= i_in;
      dot_ff       <= dot_in;
      na_ff        <= na_in;
      nb_ff        <= nb_in;
      sc_ff        <= sc_in;
      best_ff      <= best_in;
      best_slot_ff <= best_slot_in;
      found_ff     <= found_in;
      p_ab_ff      <= q_rdata * g_rdata;
      p_aa_ff      <= q_rdata * q_rdata;
      p_bb_ff      <= g_rdata * g_rdata;
      if (out_load) begin
         rsp_d_ff <= {best_ff >= $signed({1'b0, thr_ff}), best_ff,
                      SLOT_FW'(best_slot_ff), found_ff};
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

endmodule
